/* rtl/core/mld_pkg.sv */
// ----------------------------------------------------------------------------
// mld_pkg: shared types and constants for the masked Laplacian diffusion step
// Grid geometry, payload structs, sequencer states.
// ----------------------------------------------------------------------------
package mld_pkg;

  localparam int unsigned GridX = 16;
  localparam int unsigned GridY = 16;
  localparam int unsigned GridZ = 16;
  localparam int unsigned Cells = GridX * GridY * GridZ;
  localparam int unsigned AddrW = $clog2(Cells);
  localparam int unsigned IdxW  = 4;
  localparam int unsigned DataW = 32;
  localparam int unsigned CellW = 3 * DataW + 1;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgGainX = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgGainY = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgGainZ = 2'd2;

  localparam logic FuncLoad    = 1'b0;
  localparam logic FuncCompute = 1'b1;

  typedef struct packed {
    logic               func;
    logic [IdxW-1:0]    cell_i;
    logic [IdxW-1:0]    cell_j;
    logic [IdxW-1:0]    cell_k;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic               fluid;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } out_beat_t;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StWait,
    StMul,
    StAcc,
    StDone
  } state_e;

endpackage

/* rtl/core/mld_ram.sv */
// ----------------------------------------------------------------------------
// mld_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module mld_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

/* rtl/core/masked_laplacian_diffusion_step_top.sv */
// ----------------------------------------------------------------------------
// masked_laplacian_diffusion_step_top: one explicit diffusion step per cell
// Load beats write a cell; compute beats return the 7-point masked update.
// ----------------------------------------------------------------------------
// Load beat: an in-grid cell is written at the accepting edge; busy stays low, next
// beat the cycle after. Compute beat: busy through the valid_o strobe, next beat the
// cycle after. Center read overlaps acceptance; six neighbor reads (StRead, StWait)
// on the one cell RAM port, nine products (StMul, StAcc) on one shared 35x32
// multiplier. An air center strobes after its read, unchanged; off-grid gives zero.
// Reset clears the gains and the sequencer; the cell RAM is not cleared. No stall.
module masked_laplacian_diffusion_step_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  mld_pkg::in_beat_t             in_i,
  output logic                          valid_o,
  output mld_pkg::out_beat_t            out_o,
  input  logic                          cfg_we_i,
  input  logic [mld_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [31:0]                   cfg_data_i
);
  import mld_pkg::*;

  // Config registers
  logic [31:0] gain_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q[0] <= '0;
      gain_q[1] <= '0;
      gain_q[2] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgGainX: gain_q[0] <= cfg_data_i;
        CfgGainY: gain_q[1] <= cfg_data_i;
        CfgGainZ: gain_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer state
  state_e state_q, state_d;
  logic [2:0] rd_q, rd_d;        // read slot 0 center, 1..6 neighbors
  logic [1:0] ax_q, ax_d;        // axis for the multiplier
  logic [1:0] cp_q, cp_d;        // component for the multiplier
  logic [IdxW-1:0] ci_q, cj_q, ck_q;
  logic in_grid_q;

  // Cell RAM: {x, y, z, fluid}
  logic             ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [CellW-1:0] ram_wdata, ram_rdata;

  mld_ram #(.Width(CellW), .Depth(Cells)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // Neighbor address for the current read slot
  logic [IdxW:0] ni, nj, nk;     // one extra bit to catch wrap past the edge
  logic          nb_in;
  always_comb begin
    ni = {1'b0, ci_q};
    nj = {1'b0, cj_q};
    nk = {1'b0, ck_q};
    case (rd_q)
      3'd1: ni = ni + 1'b1;
      3'd2: ni = ni - 1'b1;
      3'd3: nj = nj + 1'b1;
      3'd4: nj = nj - 1'b1;
      3'd5: nk = nk + 1'b1;
      3'd6: nk = nk - 1'b1;
      default: ;
    endcase
    nb_in = (ni < (IdxW+1)'(GridX)) && (nj < (IdxW+1)'(GridY))
         && (nk < (IdxW+1)'(GridZ));
  end

  logic in_grid_now;
  assign in_grid_now = ({1'b0, in_i.cell_i} < (IdxW+1)'(GridX))
                    && ({1'b0, in_i.cell_j} < (IdxW+1)'(GridY))
                    && ({1'b0, in_i.cell_k} < (IdxW+1)'(GridZ));

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = {in_i.vel_x, in_i.vel_y, in_i.vel_z, in_i.fluid};
    ram_addr  = AddrW'((ni[IdxW-1:0] * GridY + nj[IdxW-1:0]) * GridZ + nk[IdxW-1:0]);
    if (state_q == StIdle) begin
      ram_addr = AddrW'((in_i.cell_i * GridY + in_i.cell_j) * GridZ + in_i.cell_k);
      ram_we   = start && (in_i.func == FuncLoad) && in_grid_now;
    end
  end

  // Captured neighbors: slot 0 center, a masked neighbor holds the center value
  // so its difference vanishes.
  logic signed [31:0] val_q [7][3];
  logic               ctr_fluid_q;
  logic               nb_ok_q;

  // Multiplier: d (35 bits signed) times gain (32 bits unsigned)
  logic signed [34:0] mul_d;
  logic signed [67:0] prod_q;
  logic signed [69:0] acc_q [3];
  logic signed [31:0] ctr;
  always_comb begin
    ctr   = val_q[0][cp_q];
    mul_d = 35'(val_q[{ax_q, 1'b0} + 3'd1][cp_q]) + 35'(val_q[{ax_q, 1'b0} + 3'd2][cp_q])
          - (35'(ctr) <<< 1);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (start && in_i.func == FuncCompute) begin
        state_d = in_grid_now ? StWait : StDone;
      end
      StRead: state_d = StWait;
      StWait: begin
        if (rd_q == 3'd0 && !ram_rdata[0]) state_d = StDone;
        else if (rd_q == 3'd6) state_d = StMul;
        else state_d = StRead;
      end
      StMul: state_d = StAcc;
      StAcc: if (ax_q == 2'd2 && cp_q == 2'd2) state_d = StDone;
             else state_d = StMul;
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Counter updates
  always_comb begin
    rd_d = rd_q;
    ax_d = ax_q;
    cp_d = cp_q;
    unique case (state_q)
      StIdle: begin
        rd_d = 3'd0;
        ax_d = 2'd0;
        cp_d = 2'd0;
      end
      StWait: rd_d = (rd_q == 3'd6) ? rd_q : rd_q + 3'd1;
      StAcc: begin
        if (ax_q == 2'd2) begin
          ax_d = 2'd0;
          cp_d = (cp_q == 2'd2) ? cp_q : cp_q + 2'd1;
        end else begin
          ax_d = ax_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      rd_q    <= '0;
      ax_q    <= '0;
      cp_q    <= '0;
    end else begin
      state_q <= state_d;
      rd_q    <= rd_d;
      ax_q    <= ax_d;
      cp_q    <= cp_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start) begin
      ci_q      <= in_i.cell_i;
      cj_q      <= in_i.cell_j;
      ck_q      <= in_i.cell_k;
      in_grid_q <= in_grid_now;
      acc_q[0]  <= '0;
      acc_q[1]  <= '0;
      acc_q[2]  <= '0;
    end
    if (state_q == StRead || state_q == StIdle) begin
      nb_ok_q <= (state_q == StIdle) ? 1'b1 : nb_in;
    end
    if (state_q == StWait) begin
      if (rd_q == 3'd0) begin
        ctr_fluid_q <= ram_rdata[0];
        val_q[0][0] <= ram_rdata[96:65];
        val_q[0][1] <= ram_rdata[64:33];
        val_q[0][2] <= ram_rdata[32:1];
      end else if (nb_ok_q && ram_rdata[0]) begin
        val_q[rd_q][0] <= ram_rdata[96:65];
        val_q[rd_q][1] <= ram_rdata[64:33];
        val_q[rd_q][2] <= ram_rdata[32:1];
      end else begin
        val_q[rd_q][0] <= val_q[0][0];
        val_q[rd_q][1] <= val_q[0][1];
        val_q[rd_q][2] <= val_q[0][2];
      end
    end
    if (state_q == StMul) begin
      prod_q <= 68'(mul_d) * $signed({36'd0, gain_q[ax_q]});
    end
    if (state_q == StAcc) begin
      acc_q[cp_q] <= acc_q[cp_q] + 70'(prod_q);
    end
  end

  // Round by 2^-24 (half up), add center, saturate
  function automatic logic signed [31:0] finish(input logic signed [69:0] acc,
                                                input logic signed [31:0] c);
    logic signed [45:0] t;
    logic signed [46:0] r;
    begin
      t = 46'((acc + 70'sd8388608) >>> 24);
      r = 47'(t) + 47'(c);
      if (r > 47'sd2147483647) finish = 32'sh7fffffff;
      else if (r < -47'sd2147483648) finish = 32'sh80000000;
      else finish = r[31:0];
    end
  endfunction

  // Outputs
  always_comb begin
    busy    = (state_q != StIdle);
    valid_o = (state_q == StDone);
    if (!in_grid_q) begin
      out_o = '0;
    end else if (!ctr_fluid_q) begin
      out_o = {val_q[0][0], val_q[0][1], val_q[0][2]};
    end else begin
      out_o.out_x = finish(acc_q[0], val_q[0][0]);
      out_o.out_y = finish(acc_q[1], val_q[0][1]);
      out_o.out_z = finish(acc_q[2], val_q[0][2]);
    end
  end

`ifndef SYNTHESIS
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result strobe longer than one beat");
  a_busy_after_compute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_i.func == FuncCompute) |=> busy)
    else $error("compute beat not taken");
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_i.func == FuncLoad) |=> !busy && !valid_o)
    else $error("load beat produced a result");
  a_counters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_q != 3'd7 && cp_q != 2'd3 && ax_q != 2'd3) else $error("counter overrun");
`endif
endmodule
